/* sv/assert_macros.svh */
// Assertion macros shared by the discordant pair filter RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define DPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge; the property guards reset itself.
`define DPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/dpf_pkg.sv */
// Package for the discordant pair filter: widths, register codes, flag bits,
// the classification and configuration structs and the saturating increment.
package dpf_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int FLAG_W     = 12;
  localparam int POS_W      = 32;
  localparam int LEN_W      = 16;
  localparam int THR_W      = 31;
  localparam int CNT_W      = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INSERT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OVERLAP = CFG_IDX_W'(1);

  localparam logic [THR_W-1:0] MIN_INSERT_RST  = THR_W'(1000);
  localparam logic [LEN_W-1:0] MAX_OVERLAP_RST = LEN_W'(90);

  // Alignment flag bit positions
  localparam int FLG_UNMAPPED  = 2;
  localparam int FLG_REVERSE   = 4;
  localparam int FLG_MREVERSE  = 5;
  localparam int FLG_SECONDARY = 8;
  localparam int FLG_SUPPL     = 11;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [THR_W-1:0] min_insert;
    logic [LEN_W-1:0] max_overlap;
  } cfg_t;

  // Classification of the record held in the input register
  typedef struct packed {
    logic valid;
    logic skip;
    logic keep;
    logic fwd;
    logic rvs;
    logic outw;
    logic longi;
    logic xref;
  } cls_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c, input logic hit);
    sat_inc = (hit && (c != CNT_MAX)) ? c + CNT_W'(1) : c;
  endfunction

endpackage

/* sv/dpf_in_if.sv */
// Record input channel of the discordant pair filter.
// Depends on dpf_pkg for field widths.
interface dpf_in_if;
  import dpf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [FLAG_W-1:0]       flag_word;
  logic signed [POS_W-1:0] read_start;
  logic signed [POS_W-1:0] mate_start;
  logic signed [POS_W-1:0] ref_id;
  logic signed [POS_W-1:0] mate_ref_id;
  logic signed [POS_W-1:0] insert_size;
  logic [LEN_W-1:0]        read_length;

  modport source (output valid, flag_word, read_start, mate_start, ref_id, mate_ref_id,
                  insert_size, read_length, input ready);
  modport sink (input valid, flag_word, read_start, mate_start, ref_id, mate_ref_id,
                insert_size, read_length, output ready);
endinterface

/* sv/dpf_out_if.sv */
// Result channel of the discordant pair filter.
// Depends on dpf_pkg for counter width.
interface dpf_out_if;
  import dpf_pkg::*;

  logic             valid;
  logic             ready;
  logic             keep;
  logic             skipped;
  logic [CNT_W-1:0] same_forward_count;
  logic [CNT_W-1:0] same_reverse_count;
  logic [CNT_W-1:0] outward_count;
  logic [CNT_W-1:0] long_insert_count;
  logic [CNT_W-1:0] cross_ref_count;

  modport source (output valid, keep, skipped, same_forward_count, same_reverse_count,
                  outward_count, long_insert_count, cross_ref_count, input ready);
  modport sink (input valid, keep, skipped, same_forward_count, same_reverse_count,
                outward_count, long_insert_count, cross_ref_count, output ready);
endinterface

/* sv/dpf_cfg_if.sv */
// Configuration write channel of the discordant pair filter.
// Depends on dpf_pkg for index and data widths.
interface dpf_cfg_if;
  import dpf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/dpf_cfg_regs.sv */
// Configuration registers of the discordant pair filter.
// Depends on dpf_pkg and dpf_cfg_if.
module dpf_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  dpf_cfg_if.sink       cfg_ch,
  output dpf_pkg::cfg_t cfg
);
  import dpf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Always ready; unknown indexes are dropped
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MIN_INSERT:  cfg_nxt.min_insert  = cfg_ch.data[THR_W-1:0];
        CFG_MAX_OVERLAP: cfg_nxt.max_overlap = cfg_ch.data[LEN_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_insert  <= MIN_INSERT_RST;
      cfg_r.max_overlap <= MAX_OVERLAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/dpf_classify.sv */
// Input register and record classification of the discordant pair filter.
// Depends on dpf_pkg, dpf_in_if and assert_macros.svh.
`include "assert_macros.svh"

module dpf_classify (
  input  logic          clk,
  input  logic          rst_n,
  dpf_in_if.sink        in_ch,
  input  dpf_pkg::cfg_t cfg,
  input  logic          adv,
  output dpf_pkg::cls_t cls
);
  import dpf_pkg::*;

  logic                    s1_v_r;
  logic                    s1_v_nxt;
  logic [FLAG_W-1:0]       flag_r;
  logic signed [POS_W-1:0] rpos_r;
  logic signed [POS_W-1:0] mpos_r;
  logic signed [POS_W-1:0] tid_r;
  logic signed [POS_W-1:0] mtid_r;
  logic signed [POS_W-1:0] isz_r;
  logic [LEN_W-1:0]        rlen_r;

  logic                    accept;
  logic                    skip;
  logic                    rev;
  logic                    mrev;
  logic                    lim_pos;
  logic [LEN_W-1:0]        lim;
  logic signed [POS_W+1:0] lim_ext;
  logic signed [POS_W+1:0] diff_rm;
  logic signed [POS_W+1:0] diff_mr;
  logic [POS_W:0]          mag;
  logic                    xref;
  logic                    outw;
  logic                    longi;

  // Input register: holds while the result side is stalled
  assign in_ch.ready = !s1_v_r || adv;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flag_r <= in_ch.flag_word;
      rpos_r <= in_ch.read_start;
      mpos_r <= in_ch.mate_start;
      tid_r  <= in_ch.ref_id;
      mtid_r <= in_ch.mate_ref_id;
      isz_r  <= in_ch.insert_size;
      rlen_r <= in_ch.read_length;
    end
  end

  // Flag decode
  assign skip = flag_r[FLG_UNMAPPED] | flag_r[FLG_SECONDARY] | flag_r[FLG_SUPPL];
  assign rev  = flag_r[FLG_REVERSE];
  assign mrev = flag_r[FLG_MREVERSE];

  // Outward test: start gap beyond read length minus overlap, no wrap
  assign lim_pos = rlen_r > cfg.max_overlap;
  assign lim     = rlen_r - cfg.max_overlap;
  assign lim_ext = $signed({{(POS_W+2-LEN_W){1'b0}}, lim});
  assign diff_rm = $signed({{2{rpos_r[POS_W-1]}}, rpos_r}) -
                   $signed({{2{mpos_r[POS_W-1]}}, mpos_r});
  assign diff_mr = $signed({{2{mpos_r[POS_W-1]}}, mpos_r}) -
                   $signed({{2{rpos_r[POS_W-1]}}, rpos_r});

  assign xref  = tid_r != mtid_r;
  assign outw  = lim_pos && !xref &&
                 ((!rev && mrev && (diff_rm > lim_ext)) ||
                  (rev && !mrev && (diff_mr > lim_ext)));

  // Exact magnitude of the insert size, 33 bits
  assign mag   = isz_r[POS_W-1] ? ((POS_W+1)'(0) - {isz_r[POS_W-1], isz_r})
                                : {1'b0, isz_r};
  assign longi = mag >= {2'b00, cfg.min_insert};

  always_comb begin
    cls.valid = s1_v_r;
    cls.skip  = skip;
    cls.fwd   = !skip && !rev && !mrev;
    cls.rvs   = !skip && rev && mrev;
    cls.outw  = !skip && outw;
    cls.longi = !skip && longi;
    cls.xref  = !skip && xref;
    cls.keep  = cls.fwd | cls.rvs | cls.outw | cls.longi | cls.xref;
  end

  `DPF_ASSERT(a_s1_hold, s1_v_r && !adv |=> s1_v_r, "input register dropped a stalled record")
  `DPF_ASSERT(a_skip_no_keep, cls.skip |-> !cls.keep, "skipped record classified as kept")

endmodule

/* sv/dpf_counters.sv */
// Category counters and result register of the discordant pair filter.
// Depends on dpf_pkg, dpf_out_if and assert_macros.svh.
`include "assert_macros.svh"

module dpf_counters (
  input  logic          clk,
  input  logic          rst_n,
  input  dpf_pkg::cls_t cls,
  output logic          adv,
  dpf_out_if.source     out_ch
);
  import dpf_pkg::*;

  logic             out_v_r;
  logic             out_v_nxt;
  logic             keep_r;
  logic             skip_r;
  logic [CNT_W-1:0] fwd_r;
  logic [CNT_W-1:0] rvs_r;
  logic [CNT_W-1:0] outw_r;
  logic [CNT_W-1:0] long_r;
  logic [CNT_W-1:0] cross_r;
  logic             load;

  // Result register frees when empty or taken this cycle
  assign adv  = !out_v_r || out_ch.ready;
  assign load = cls.valid && adv;

  always_comb begin
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  // Counters move only when a record enters the result register,
  // so they always equal the counts shown with that result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      fwd_r   <= '0;
      rvs_r   <= '0;
      outw_r  <= '0;
      long_r  <= '0;
      cross_r <= '0;
    end else begin
      out_v_r <= out_v_nxt;
      if (load) begin
        fwd_r   <= sat_inc(fwd_r, cls.fwd);
        rvs_r   <= sat_inc(rvs_r, cls.rvs);
        outw_r  <= sat_inc(outw_r, cls.outw);
        long_r  <= sat_inc(long_r, cls.longi);
        cross_r <= sat_inc(cross_r, cls.xref);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      keep_r <= cls.keep;
      skip_r <= cls.skip;
    end
  end

  assign out_ch.valid              = out_v_r;
  assign out_ch.keep               = keep_r;
  assign out_ch.skipped            = skip_r;
  assign out_ch.same_forward_count = fwd_r;
  assign out_ch.same_reverse_count = rvs_r;
  assign out_ch.outward_count      = outw_r;
  assign out_ch.long_insert_count  = long_r;
  assign out_ch.cross_ref_count    = cross_r;

  `DPF_ASSERT_ALWAYS(a_fwd_step, rst_n && $past(rst_n) |-> (fwd_r == $past(fwd_r)) || (fwd_r == $past(fwd_r) + CNT_W'(1)), "forward counter moved by more than one")
  `DPF_ASSERT(a_cnt_idle, !load |=> $stable({fwd_r, rvs_r, outw_r, long_r, cross_r}), "counters changed without a record")
  `DPF_ASSERT(a_out_skip, out_v_r && skip_r |-> !keep_r, "skipped result marked keep")

endmodule

/* sv/discordant_pair_filter.sv */
// Top level of the discordant pair filter.
// Depends on dpf_pkg, the channel interfaces, dpf_cfg_regs, dpf_classify and dpf_counters.
//
// Usage:
//   in_ch  : one aligned read record per beat (flags, positions, ref ids,
//            insert size, read length); accepted when valid and ready.
//   out_ch : one result beat per record: keep, skipped and the five
//            saturating category counters as they stand after that record.
//   cfg_ch : register writes (index 0 min_insert_size, 1 max_overlap);
//            always ready, unknown indexes ignored. Write only while idle.
// Path: an accepted record waits in the input register and moves to the
//   result register when it is free; one input register, one result register.
// Throughput: one record per cycle while out_ch takes each result; classification
//   is a few compares in the single stage between the two registers.
// Reset: synchronous, active low; counters clear to zero, min_insert_size
//   returns to 1000 and max_overlap to 90, both channels empty.
// Stall: a result held by out_ch keeps the counters still; the input
//   register still takes one more record, then in_ch.ready drops until
//   the result is taken.
module discordant_pair_filter (
  input logic         clk,
  input logic         rst_n,
  dpf_in_if.sink      in_ch,
  dpf_out_if.source   out_ch,
  dpf_cfg_if.sink     cfg_ch
);
  import dpf_pkg::*;

  cfg_t cfg;
  cls_t cls;
  logic adv;

  dpf_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  dpf_classify u_classify (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg   (cfg),
    .adv   (adv),
    .cls   (cls)
  );

  dpf_counters u_counters (
    .clk    (clk),
    .rst_n  (rst_n),
    .cls    (cls),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule
